### design/rfpwfd_pkg.sv
// Shared constants and types for the RF pulse width frame decoder.
`default_nettype none

package rfpwfd_pkg;

    localparam int FILTER_LEN   = 3;
    localparam int FRAME_PULSES = 25;
    localparam int DATA_BITS    = 24;

    localparam int WIDTH_W  = 8;
    localparam int PCOUNT_W = $clog2(FRAME_PULSES + 1);
    localparam int FRAME_W  = 24;

    localparam logic [WIDTH_W-1:0] MAX_PULSE_RESET = 8'd30;
    localparam logic [WIDTH_W-1:0] MIN_PULSE_RESET = 8'd3;

    typedef enum logic [0:0] {
        CFG_MAX_PULSE = 1'b0,
        CFG_MIN_PULSE = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        STATUS_OK    = 1'b0,
        STATUS_ERROR = 1'b1
    } status_t;

endpackage

`default_nettype wire

### design/rf_pulse_width_frame_decoder.sv
// Top level of the RF pulse width frame decoder with its two-word result buffer.
//
// The slave stream carries one raw pin sample per word in s_tdata bit 0.
// Each accepted word is filtered, timed and decoded at the edge that
// accepts it; one word can be accepted in every cycle while s_tready is
// high, since the decoder holds only counters and compares.
// A finished frame or a receive error leaves as one word on the master
// stream: m_tdata holds the 24 decoded bits (zero on an error) and m_tuser
// holds the status flag. Results reach the master side from a register.
// When the receiver stalls, results wait in an output register and one
// skid register behind it; sample words keep flowing until both are full,
// and only then does s_tready drop.
// The configuration port writes the maximum and minimum pulse widths; the user
// must use it only while the block is idle; the block does not enforce it.
// Reset clears the sample history, the counters and the buffer, fills the
// shift register with ones and restores the widths to 30 and 3 ticks.
`default_nettype none

module rf_pulse_width_frame_decoder
    import rfpwfd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [0] pin_level, [7:1] zero
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [FRAME_W-1:0]       m_tdata,   // [23:0] frame_data
    output logic [0:0]               m_tuser,   // [0] status
    input  wire logic                cfg_we,
    input  wire cfg_index_t          cfg_index,
    input  wire logic [WIDTH_W-1:0]  cfg_wdata
);

    logic [WIDTH_W-1:0]    max_pulse_reg;
    logic [WIDTH_W-1:0]    min_pulse_reg;

    logic [FILTER_LEN-1:0] hist_reg, hist_next;
    logic                  level_reg, level_next;
    logic                  pending_reg, pending_next;
    logic                  high_seen_reg, high_seen_next;
    logic [WIDTH_W-1:0]    high_w_reg, high_w_next;
    logic [WIDTH_W-1:0]    low_w_reg, low_w_next;
    logic [PCOUNT_W-1:0]   pcount_reg, pcount_next;
    logic [DATA_BITS-1:0]  shift_reg, shift_next;

    logic [FILTER_LEN:0]   hist_ext;
    logic                  fail;
    logic                  done;
    logic                  s_accept;
    logic                  push;
    logic [FRAME_W-1:0]    res_data;
    status_t               res_status;

    logic                  out_valid_reg;
    logic [FRAME_W-1:0]    out_data_reg;
    status_t               out_status_reg;
    logic                  skid_valid_reg;
    logic [FRAME_W-1:0]    skid_data_reg;
    status_t               skid_status_reg;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign hist_ext = {hist_reg, s_tdata[0]};

    always_comb
    begin
        fail           = 1'b0;
        done           = 1'b0;
        hist_next      = hist_ext[FILTER_LEN-1:0];
        level_next     = level_reg;
        pending_next   = pending_reg;
        high_seen_next = high_seen_reg;
        high_w_next    = high_w_reg;
        low_w_next     = low_w_reg;
        pcount_next    = pcount_reg;
        shift_next     = shift_reg;

        if (hist_next == {FILTER_LEN{1'b1}})
        begin
            level_next = 1'b1;
        end
        else if (hist_next == '0)
        begin
            level_next = 1'b0;
        end

        if (level_next)
        begin
            if (pending_reg)
            begin
                pending_next = 1'b0;
                if (low_w_reg >= min_pulse_reg)
                begin
                    shift_next  = {shift_reg[DATA_BITS-2:0], (high_w_reg > low_w_reg)};
                    high_w_next = '0;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            else
            begin
                high_seen_next = 1'b1;
                high_w_next    = high_w_reg + 1'b1;
                if (high_w_next >= max_pulse_reg)
                begin
                    fail = 1'b1;
                end
                low_w_next = '0;
            end
        end
        else
        begin
            low_w_next = low_w_reg + 1'b1;
            if (low_w_next >= max_pulse_reg)
            begin
                if (pcount_reg != PCOUNT_W'(FRAME_PULSES))
                begin
                    fail       = 1'b1;
                    shift_next = '1;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            else if (high_seen_reg)
            begin
                high_seen_next = 1'b0;
                low_w_next     = '0;
                pending_next   = 1'b1;
                if (high_w_reg >= min_pulse_reg)
                begin
                    if (pcount_reg >= PCOUNT_W'(FRAME_PULSES))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        pcount_next = pcount_reg + 1'b1;
                    end
                end
                else
                begin
                    fail = 1'b1;
                end
            end
        end

        if (fail || done)
        begin
            pcount_next    = '0;
            high_w_next    = '0;
            low_w_next     = '0;
            high_seen_next = 1'b0;
            pending_next   = 1'b0;
        end
    end

    assign push       = s_accept && (fail || done);
    assign res_data   = done ? FRAME_W'(shift_next) : '0;
    assign res_status = done ? STATUS_OK : STATUS_ERROR;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pulse_reg <= MAX_PULSE_RESET;
            min_pulse_reg <= MIN_PULSE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_PULSE: max_pulse_reg <= cfg_wdata;
                CFG_MIN_PULSE: min_pulse_reg <= cfg_wdata;
                default:       max_pulse_reg <= max_pulse_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= '0;
            level_reg     <= 1'b0;
            pending_reg   <= 1'b0;
            high_seen_reg <= 1'b0;
            high_w_reg    <= '0;
            low_w_reg     <= '0;
            pcount_reg    <= '0;
            shift_reg     <= '1;
        end
        else if (s_accept)
        begin
            hist_reg      <= hist_next;
            level_reg     <= level_next;
            pending_reg   <= pending_next;
            high_seen_reg <= high_seen_next;
            high_w_reg    <= high_w_next;
            low_w_reg     <= low_w_next;
            pcount_reg    <= pcount_next;
            shift_reg     <= shift_next;
        end
    end

    // The skid register always holds the younger result when both are full.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg   <= skid_data_reg;
                out_status_reg <= skid_status_reg;
            end
            else
            begin
                out_data_reg   <= res_data;
                out_status_reg <= res_status;
            end
        end
        else if (push)
        begin
            skid_data_reg   <= res_data;
            skid_status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while the output register is empty");

    error_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STATUS_ERROR)) |-> (m_tdata == '0))
        else $error("error word carries nonzero frame data");

    pulse_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg <= PCOUNT_W'(FRAME_PULSES))
        else $error("pulse count exceeds the frame length");

    result_clears_counts: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (pcount_reg == '0) && (high_w_reg == '0) && (low_w_reg == '0))
        else $error("counters not cleared after a result");

endmodule

`default_nettype wire

### test/tb_rf_pulse_width_frame_decoder.sv
// Self-checking testbench for the RF pulse width frame decoder.
module tb_rf_pulse_width_frame_decoder;
    import rfpwfd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [FRAME_W-1:0] data;
        status_t            st;
    } frame_t;

    typedef struct packed {
        int unsigned        hi;
        int unsigned        lo;
        int unsigned        reps;
        bit                 typed;
        logic [FRAME_W-1:0] data;
        status_t            st;
    } pulse_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [FRAME_W-1:0] m_tdata;
    logic [0:0]         m_tuser;
    logic               cfg_we;
    cfg_index_t         cfg_index;
    logic [WIDTH_W-1:0] cfg_wdata;

    // Decoder state mirrored by the predictor.
    logic [WIDTH_W-1:0]    max_ticks;
    logic [WIDTH_W-1:0]    min_ticks;
    logic [FILTER_LEN-1:0] pin_hist;
    logic                  level_f;
    logic                  bit_wait;
    logic                  high_open;
    logic [WIDTH_W-1:0]    high_ticks;
    logic [WIDTH_W-1:0]    low_ticks;
    logic [PCOUNT_W-1:0]   pulses;
    logic [DATA_BITS-1:0]  shreg;

    frame_t     frames_due[$];
    pulse_row_t dir_plan[0:11];

    int  n_samples;
    int  n_predicted;
    int  n_ok;
    int  n_err;
    int  n_bad;
    int  n_settings;
    int  stop_at;
    int  hold_req;
    int  hold_seen;
    int  quiet;
    bit  tx_idle_on;
    bit  rx_idle_on;

    always #1 clk = ~clk;

    rf_pulse_width_frame_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    task automatic decode_sample(input bit lvl, output bit got, output frame_t res);
        bit fail;
        bit done;
        fail = 1'b0;
        done = 1'b0;
        got  = 1'b0;
        res  = '0;
        pin_hist = {pin_hist[FILTER_LEN-2:0], lvl};
        if (&pin_hist)
            level_f = 1'b1;
        else if (pin_hist == '0)
            level_f = 1'b0;
        if (level_f)
        begin
            if (bit_wait)
            begin
                bit_wait = 1'b0;
                if (low_ticks >= min_ticks)
                begin
                    shreg = {shreg[DATA_BITS-2:0], (high_ticks > low_ticks)};
                    high_ticks = '0;
                end
                else
                    fail = 1'b1;
            end
            else
            begin
                high_open  = 1'b1;
                high_ticks = high_ticks + 1'b1;
                if (high_ticks >= max_ticks)
                    fail = 1'b1;
                low_ticks = '0;
            end
        end
        else
        begin
            low_ticks = low_ticks + 1'b1;
            if (low_ticks >= max_ticks)
            begin
                if (pulses != FRAME_PULSES)
                begin
                    fail  = 1'b1;
                    shreg = '1;
                end
                else
                    done = 1'b1;
            end
            else if (high_open)
            begin
                high_open = 1'b0;
                low_ticks = '0;
                bit_wait  = 1'b1;
                if (high_ticks < min_ticks || pulses + 1 >= FRAME_PULSES + 1)
                    fail = 1'b1;
                else
                    pulses = pulses + 1'b1;
            end
        end
        if (fail || done)
        begin
            got        = 1'b1;
            res.data   = done ? FRAME_W'(shreg) : '0;
            res.st     = done ? STATUS_OK : STATUS_ERROR;
            pulses     = '0;
            high_ticks = '0;
            low_ticks  = '0;
            high_open  = 1'b0;
            bit_wait   = 1'b0;
        end
    endtask

    task automatic put_sample(input bit lvl, input bit typed = 1'b0, input frame_t want = '0);
        bit     got;
        frame_t res;
        if (tx_idle_on && $urandom_range(0, 15) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, lvl};
        do @(posedge clk); while (!s_tready);
        n_samples++;
        decode_sample(lvl, got, res);
        if (typed)
            res = want;
        if (typed || got)
        begin
            frames_due.push_back(res);
            n_predicted++;
        end
    endtask

    // Runs are cut short once the current phase has used up its sample budget.
    task automatic send_run(input bit lvl, input int len);
        repeat (len)
        begin
            if (n_samples < stop_at)
                put_sample(lvl);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_noise(input int mx);
        bit lvl;
        int len;
        repeat ($urandom_range(1, 6))
        begin
            lvl = $urandom_range(0, 1);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, mx + 3) : $urandom_range(1, 8);
            send_run(lvl, len);
        end
    endtask

    task automatic send_frame(input int mx, input int hmin, input int hmax,
                              input int lmin, input int lmax, input bit broken);
        int npulse;
        int glitch_at;
        int h;
        int l;
        npulse    = FRAME_PULSES;
        glitch_at = -1;
        if (broken)
        begin
            if ($urandom_range(0, 1) == 0)
                npulse = $urandom_range(1, FRAME_PULSES + 5);
            else
                glitch_at = $urandom_range(0, FRAME_PULSES - 1);
        end
        for (int p = 0; p < npulse; p++)
        begin
            h = $urandom_range(hmin, hmax);
            l = $urandom_range(lmin, lmax);
            if (p == glitch_at)
            begin
                if ($urandom_range(0, 1) == 0)
                    h = $urandom_range(1, 3);
                else
                    l = $urandom_range(1, 3);
            end
            if (p == npulse - 1)
                l = mx + 2 + $urandom_range(0, 2);
            send_run(1'b1, h);
            send_run(1'b0, l);
        end
    endtask

    task automatic run_phase(input int mx, input int mn, input int budget, input bit idle,
                             input bit hold);
        int  hmin;
        int  hmax;
        int  lmin;
        int  lmax;
        bit  framable;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_PULSE;
        cfg_wdata <= WIDTH_W'(mx);
        @(posedge clk);
        cfg_index <= CFG_MIN_PULSE;
        cfg_wdata <= WIDTH_W'(mn);
        @(posedge clk);
        cfg_we    <= 1'b0;
        max_ticks = WIDTH_W'(mx);
        min_ticks = WIDTH_W'(mn);
        n_settings++;
        tx_idle_on = idle;
        rx_idle_on = idle;
        if (hold)
            hold_req++;
        // A well-formed pulse must pass the minimum checks and stay below the maximum.
        hmin = (mn + 1 > 3) ? mn + 1 : 3;
        lmin = hmin;
        hmax = (mx - 1 < hmin + 2) ? mx - 1 : hmin + 2;
        lmax = (mx < lmin + 2) ? mx : lmin + 2;
        framable = (hmin <= hmax) && (lmin <= lmax);
        stop_at = n_samples + budget;
        while (n_samples < stop_at)
        begin
            if (framable && $urandom_range(0, 3) != 0)
                send_frame(mx, hmin, hmax, lmin, lmax, $urandom_range(0, 4) == 0);
            else
                send_noise(mx);
        end
        settle();
    endtask

    initial
    begin : rx_side
        frame_t want;
        int     stall;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (frames_due.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("Unexpected word: data %06h status %0d", m_tdata, m_tuser);
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (want.st == STATUS_OK)
                        n_ok++;
                    else
                        n_err++;
                    if (m_tdata !== want.data || m_tuser !== want.st)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("Mismatch: expected data %06h status %0d, got data %06h status %0d",
                                     want.data, want.st, m_tdata, m_tuser);
                    end
                end
            end
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                stall = LONG_HOLD;
            end
            else if (stall == 0 && rx_idle_on && $urandom_range(0, 11) == 0)
                stall = $urandom_range(1, 16);
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT)
            begin
                $display("Timeout after %0d quiet cycles.", QUIET_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin : tx_side
        int unsigned total;
        int unsigned k;
        frame_t      want;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_MAX_PULSE;
        cfg_wdata  = '0;
        quiet      = 0;
        n_samples  = 0;
        n_predicted = 0;
        n_ok       = 0;
        n_err      = 0;
        n_bad      = 0;
        n_settings = 1;
        stop_at    = 0;
        hold_req   = 0;
        hold_seen  = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        max_ticks  = MAX_PULSE_RESET;
        min_ticks  = MIN_PULSE_RESET;
        pin_hist   = '0;
        level_f    = 1'b0;
        bit_wait   = 1'b0;
        high_open  = 1'b0;
        high_ticks = '0;
        low_ticks  = '0;
        pulses     = '0;
        shreg      = '1;

        // Each row sends reps times a high of hi samples and a low of lo samples,
        // at the reset widths of 30 and 3 ticks.
        dir_plan = '{
            '{0,  30, 1,  1'b1, 24'h000000, STATUS_ERROR},  // idle low line
            '{32, 0,  1,  1'b1, 24'h000000, STATUS_ERROR},  // over-long high
            '{0,  3,  1,  1'b1, 24'h000000, STATUS_ERROR},  // short high
            '{5,  3,  1,  1'b0, 24'h000000, STATUS_OK},
            '{3,  0,  1,  1'b1, 24'h000000, STATUS_ERROR},  // short low
            '{0,  3,  1,  1'b1, 24'h000000, STATUS_ERROR},  // short high
            '{5,  4,  12, 1'b0, 24'h000000, STATUS_OK},     // one bits
            '{4,  6,  13, 1'b0, 24'h000000, STATUS_OK},     // zero bits
            '{0,  27, 1,  1'b1, 24'hFFF000, STATUS_OK},     // frame end
            '{5,  4,  25, 1'b0, 24'h000000, STATUS_OK},
            '{5,  3,  1,  1'b1, 24'h000000, STATUS_ERROR},  // one pulse too many
            '{5,  33, 1,  1'b1, 24'h000000, STATUS_ERROR}   // frame end with one pulse
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_plan[i])
        begin
            total = dir_plan[i].reps * (dir_plan[i].hi + dir_plan[i].lo);
            want.data = dir_plan[i].data;
            want.st   = dir_plan[i].st;
            k = 0;
            repeat (dir_plan[i].reps)
            begin
                repeat (dir_plan[i].hi)
                begin
                    put_sample(1'b1, dir_plan[i].typed && k == total - 1, want);
                    k++;
                end
                repeat (dir_plan[i].lo)
                begin
                    put_sample(1'b0, dir_plan[i].typed && k == total - 1, want);
                    k++;
                end
            end
        end
        settle();

        run_phase(30,  3,   70,  1'b1, 1'b0);
        run_phase(255, 0,   50,  1'b1, 1'b0);
        run_phase(1,   255, 40,  1'b1, 1'b1);
        run_phase(20,  5,   50,  1'b1, 1'b0);
        run_phase(6,   1,   80,  1'b1, 1'b0);
        run_phase(12,  2,   245, 1'b0, 1'b0);

        if (frames_due.size() != 0)
            n_bad++;
        $display("Sent %0d pin samples over %0d width settings, with idle and stalled stretches.",
                 n_samples, n_settings);
        $display("Checked %0d decoded frames and %0d receive errors.", n_ok, n_err);
        if (n_bad == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
